// ===== hdl/pclc_pkg.sv =====
// ----------------------------------------------------------------------------
// pclc_pkg
// Shared constants and types for the phase cycle launch control block.
// ----------------------------------------------------------------------------
package pclc_pkg;

    localparam int FULL_SCALE = 32000;  // 10 V in phase units
    localparam int STEP_W     = 7;
    localparam int PULSE_W    = 16;
    localparam int CFG_W      = 16;
    localparam int STEPS_MIN  = 2;
    localparam int STEPS_MAX  = 64;

    typedef enum logic [0:0] {
        CFG_STEP_COUNT    = 1'b0,
        CFG_PULSE_SAMPLES = 1'b1
    } cfg_index_t;

    typedef logic [PULSE_W-1:0] pulse_len_t;
    typedef logic [STEP_W-1:0]  step_count_t;

endpackage

// ===== hdl/pclc_pulse.sv =====
// ----------------------------------------------------------------------------
// pclc_pulse
// Retriggerable pulse stretcher: a trigger extends the remaining count to the
// longer of the current remainder and the pulse length.
// ----------------------------------------------------------------------------
module pclc_pulse
    import pclc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       trigger,
    input  pulse_len_t pulse_len,
    output logic       active
);

    pulse_len_t remaining_reg;
    pulse_len_t remaining_next;
    pulse_len_t loaded;

    always_comb
    begin
        loaded = remaining_reg;
        if (trigger && (pulse_len > remaining_reg))
        begin
            loaded = pulse_len;
        end
        active         = (loaded != '0);
        remaining_next = active ? (loaded - pulse_len_t'(1)) : loaded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
        end
        else if (advance)
        begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ===== hdl/phase_cycle_launch_control.sv =====
// ----------------------------------------------------------------------------
// phase_cycle_launch_control
// Arms on jack edges or on button edges while idle, launches one phase cycle on the next wrap,
// and fires step and end-of-cycle pulses while the cycle runs.
// ----------------------------------------------------------------------------
// Result: each accepted input item's result item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver is ready; the output register frees while it is read.
// Per-item path: two phase-by-step multiplies and a bank of threshold compares.
// Reset: all flags, pulse counters and phase registers clear, edge detectors
// start high, step_count returns to 8 and pulse_samples to 48.
module phase_cycle_launch_control
    import pclc_pkg::*;
#(
    parameter int PHASE_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [CFG_W-1:0]                     cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // phase_sample, arm_jack, arm_button, zero fill
    input  logic [((PHASE_WIDTH+2+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // phase_thru, running_flag, armed_flag, step_pulse, end_pulse, zero fill
    output logic [((PHASE_WIDTH+4+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int PW     = PHASE_WIDTH;
    localparam int OUT_W  = ((PW + 4 + 7) / 8) * 8;
    localparam int PROD_W = PW + STEP_W + 1;
    localparam int CMP_W  = (PROD_W > 23) ? PROD_W : 23;

    // Configuration
    step_count_t step_count_reg;
    pulse_len_t  pulse_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg    <= step_count_t'(8);
            pulse_samples_reg <= pulse_len_t'(48);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_COUNT:    step_count_reg    <= cfg_data[STEP_W-1:0];
                CFG_PULSE_SAMPLES: pulse_samples_reg <= cfg_data[PULSE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshake
    logic in_fire;
    logic out_valid_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    logic signed [PW-1:0] phase;
    logic                 jack;
    logic                 button;

    assign phase  = $signed(s_axis_tdata[PW-1:0]);
    assign jack   = s_axis_tdata[PW];
    assign button = s_axis_tdata[PW+1];

    // State
    logic                 armed_reg;
    logic                 running_reg;
    logic signed [PW-1:0] previous_phase_reg;
    logic signed [PW-1:0] held_phase_reg;
    logic                 jack_last_reg;
    logic                 button_last_reg;

    logic                 armed_next;
    logic                 running_next;
    logic signed [PW-1:0] held_phase_next;
    logic                 armed_pre;
    logic                 wrap;
    logic                 start;
    logic                 run_pre;
    logic                 stop;
    logic signed [PW-1:0] ref_phase;
    step_count_t          steps;

    always_comb
    begin
        armed_pre = armed_reg
                    || (jack && !jack_last_reg)
                    || (button && !button_last_reg && !running_reg);
        wrap      = (phase < previous_phase_reg);
        start     = armed_pre && wrap;
        run_pre   = running_reg || start;
        armed_next = armed_pre && !start;
        // the start item's own sample is the reference: no stop, no crossing
        ref_phase = start ? phase : previous_phase_reg;
        stop      = run_pre && !start && wrap;
        running_next    = run_pre && !stop;
        held_phase_next = run_pre ? phase : held_phase_reg;

        if (step_count_reg < step_count_t'(STEPS_MIN))
        begin
            steps = step_count_t'(STEPS_MIN);
        end
        else if (step_count_reg > step_count_t'(STEPS_MAX))
        begin
            steps = step_count_t'(STEPS_MAX);
        end
        else
        begin
            steps = step_count_reg;
        end
    end

    // Division crossings: ref * steps <= k * FULL_SCALE < phase * steps
    logic signed [PROD_W-1:0] prod_new;
    logic signed [PROD_W-1:0] prod_ref;
    logic signed [CMP_W-1:0]  scaled_new;
    logic signed [CMP_W-1:0]  scaled_ref;
    logic [STEPS_MAX-1:1]     hit;
    logic                     crossing;

    assign prod_new   = phase * $signed({1'b0, steps});
    assign prod_ref   = ref_phase * $signed({1'b0, steps});
    assign scaled_new = CMP_W'(prod_new);
    assign scaled_ref = CMP_W'(prod_ref);

    for (genvar k = 1; k < STEPS_MAX; k++)
    begin : g_div
        localparam logic signed [CMP_W-1:0] THR = CMP_W'(k * FULL_SCALE);
        assign hit[k] = (step_count_t'(k) < steps)
                        && (scaled_new > THR) && (scaled_ref <= THR);
    end

    assign crossing = running_next && (|hit);

    // Pulses
    logic step_active;
    logic end_active;

    pclc_pulse u_step_pulse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (in_fire),
        .trigger   (stop || crossing),
        .pulse_len (pulse_samples_reg),
        .active    (step_active)
    );

    pclc_pulse u_end_pulse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (in_fire),
        .trigger   (stop),
        .pulse_len (pulse_samples_reg),
        .active    (end_active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg          <= 1'b0;
            running_reg        <= 1'b0;
            previous_phase_reg <= '0;
            held_phase_reg     <= '0;
            jack_last_reg      <= 1'b1;
            button_last_reg    <= 1'b1;
        end
        else if (in_fire)
        begin
            armed_reg          <= armed_next;
            running_reg        <= running_next;
            previous_phase_reg <= phase;
            held_phase_reg     <= held_phase_next;
            jack_last_reg      <= jack;
            button_last_reg    <= button;
        end
    end

    // Output register
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= OUT_W'({end_active, step_active, armed_next,
                                    running_next, held_phase_next});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams phase samples with arm jack and button levels into the launch
// control block, predicts each output tick in the bench and compares every
// output item field by field, across several step and pulse settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pclc_pkg::*;

    localparam int PW         = 16;
    localparam int IN_W       = ((PW + 2 + 7) / 8) * 8;
    localparam int OUT_W      = ((PW + 4 + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 200000;

    // packed to match m_axis_tdata from bit 0 up
    typedef struct packed {
        logic          end_pulse;
        logic          step_pulse;
        logic          armed_flag;
        logic          running_flag;
        logic [PW-1:0] phase_thru;
    } tick_out_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    cfg_index_t        cfg_index = CFG_STEP_COUNT;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // phase_sample, arm_jack, arm_button, zero fill
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // phase_thru, running_flag, armed_flag, step_pulse, end_pulse, zero fill
    logic [OUT_W-1:0]  m_axis_tdata;

    phase_cycle_launch_control #(.PHASE_WIDTH(PW)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // bench copy of the block state and settings
    int        step_cfg = 8;
    int        pulse_cfg = 48;
    bit        armed_q = 1'b0;
    bit        running_q = 1'b0;
    int        prev_phase_q = 0;
    logic [PW-1:0] held_phase_q = '0;
    bit        jack_q = 1'b1;
    bit        button_q = 1'b1;
    int        step_left = 0;
    int        end_left = 0;

    logic [IN_W-1:0] sample_queue[$];
    tick_out_t       predicted_ticks[$];
    bit              failed = 1'b0;

    // stimulus generator levels
    bit gen_jack = 1'b0;
    bit gen_button = 1'b0;
    int gen_count = 0;

    function automatic int stretch(input int remaining);
        return (pulse_cfg > remaining) ? pulse_cfg : remaining;
    endfunction

    function automatic tick_out_t launch_tick(input logic [IN_W-1:0] item);
        int        phase;
        int        steps;
        int        thr;
        bit        jack;
        bit        button;
        tick_out_t r;
        phase  = $signed(item[PW-1:0]);
        jack   = item[PW];
        button = item[PW+1];

        if (jack && !jack_q)
            armed_q = 1'b1;
        jack_q = jack;
        if (button && !button_q && !running_q)
            armed_q = 1'b1;
        button_q = button;

        // the start tick's sample becomes the reference so the run keeps going
        if (armed_q && phase < prev_phase_q)
        begin
            running_q    = 1'b1;
            armed_q      = 1'b0;
            prev_phase_q = phase;
        end

        if (running_q)
        begin
            held_phase_q = phase[PW-1:0];
            if (phase < prev_phase_q)
            begin
                running_q = 1'b0;
                end_left  = stretch(end_left);
                step_left = stretch(step_left);
            end
        end

        steps = step_cfg;
        if (steps < STEPS_MIN)
            steps = STEPS_MIN;
        if (steps > STEPS_MAX)
            steps = STEPS_MAX;

        if (running_q)
        begin
            for (int k = 1; k < steps; k++)
            begin
                thr = k * FULL_SCALE;
                if (phase * steps > thr && prev_phase_q * steps <= thr)
                    step_left = stretch(step_left);
            end
        end

        r.phase_thru   = held_phase_q;
        r.running_flag = running_q;
        r.armed_flag   = armed_q;
        r.step_pulse   = (step_left > 0);
        r.end_pulse    = (end_left > 0);
        if (step_left > 0)
            step_left--;
        if (end_left > 0)
            end_left--;
        prev_phase_q = phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic            next_valid;
        logic [IN_W-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_ticks.push_back(launch_tick(s_axis_tdata));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                    gap_left--;
                else if (sample_queue.size() > 0)
                begin
                    next_data  = sample_queue.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, reselected each time the position counter wraps
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = 16'hFFFF;
    int          ready_pos = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (ready_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'h00FF;
                    default: ready_pattern = 16'($urandom | $urandom);
                endcase
            end
            ready_pos = (ready_pos + 1) % 64;
            m_axis_tready <= ready_pattern[ready_pos % 16];
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tick_out_t got;
        tick_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(tick_out_t)-1:0];
            if (predicted_ticks.size() == 0)
            begin
                $error("output item with no prediction pending: %h", m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = predicted_ticks.pop_front();
                if (got.phase_thru !== want.phase_thru)
                begin
                    $error("phase_thru: expected %0d, got %0d",
                           $signed(want.phase_thru), $signed(got.phase_thru));
                    failed = 1'b1;
                end
                if (got.running_flag !== want.running_flag)
                begin
                    $error("running_flag: expected %b, got %b",
                           want.running_flag, got.running_flag);
                    failed = 1'b1;
                end
                if (got.armed_flag !== want.armed_flag)
                begin
                    $error("armed_flag: expected %b, got %b",
                           want.armed_flag, got.armed_flag);
                    failed = 1'b1;
                end
                if (got.step_pulse !== want.step_pulse)
                begin
                    $error("step_pulse: expected %b, got %b",
                           want.step_pulse, got.step_pulse);
                    failed = 1'b1;
                end
                if (got.end_pulse !== want.end_pulse)
                begin
                    $error("end_pulse: expected %b, got %b",
                           want.end_pulse, got.end_pulse);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("** phase_cycle_launch_control: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_sample(input int phase, input bit jack, input bit button);
        logic [IN_W-1:0] item;
        item = '0;
        item[PW-1:0] = phase[PW-1:0];
        item[PW]     = jack;
        item[PW+1]   = button;
        sample_queue.push_back(item);
        gen_count++;
    endtask

    // sawtooth ramps with random arm edges, broken up by noise
    task automatic push_ramps(input int count);
        int start;
        int top;
        int inc;
        int p;
        int stop_at;
        stop_at = gen_count + count;
        while (gen_count < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    push_sample($urandom_range(0, 65535), $urandom_range(0, 1),
                                $urandom_range(0, 1));
            end
            else
            begin
                start = ($urandom_range(0, 5) == 0) ? -$urandom_range(1, 3000)
                                                    : $urandom_range(0, 1500);
                top   = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(28000, 32767);
                inc   = ($urandom_range(0, 3) == 0) ? $urandom_range(3000, 12000)
                                                    : $urandom_range(300, 2500);
                p = start;
                while (gen_count < stop_at)
                begin
                    if ($urandom_range(0, 24) == 0)
                        gen_jack = !gen_jack;
                    if ($urandom_range(0, 29) == 0)
                        gen_button = !gen_button;
                    if (p > top)
                        p = top;
                    push_sample(p, gen_jack, gen_button);
                    if (p >= top)
                        break;
                    p += inc;
                end
            end
        end
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_axis_tvalid || predicted_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input int steps_val, input int pulse_val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEP_COUNT;
        cfg_data  <= steps_val[CFG_W-1:0] & 16'h007F;
        @(posedge clk);
        step_cfg   = steps_val & 32'h7F;
        cfg_index <= CFG_PULSE_SAMPLES;
        cfg_data  <= pulse_val[CFG_W-1:0];
        @(posedge clk);
        pulse_cfg  = pulse_val & 32'hFFFF;
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults
        push_sample(0, 0, 0);            // levels low after reset: no edge
        push_sample(32767, 0, 0);
        push_sample(32767, 1, 0);        // jack edge arms
        push_sample(-32768, 1, 0);       // wrap launches the run
        push_sample(0, 0, 0);
        push_sample(4000, 0, 0);         // exactly on a division: no crossing
        push_sample(4001, 0, 0);         // crosses it
        push_sample(8000, 0, 1);         // button while running: ignored
        push_sample(16000, 1, 1);        // jack while running: arms anyway
        push_sample(32767, 0, 0);        // past full scale
        push_sample(100, 0, 0);          // wrap with armed set
        push_sample(20000, 0, 0);
        push_sample(50, 0, 0);           // wrap ends the run
        push_sample(60, 0, 0);
        push_sample(70, 0, 1);           // button edge while idle arms
        push_sample(-1, 0, 1);           // wrap to negative launches
        push_sample(31999, 0, 0);        // crosses every division at once
        push_sample(32000, 0, 0);
        push_sample(-32768, 0, 0);       // wrap ends the run
        push_sample(-32768, 1, 0);
        push_sample(-32768, 1, 0);       // flat: no wrap
        push_sample(-32767, 0, 0);
        push_sample(-32768, 0, 0);       // launch on a one-unit wrap
        push_sample(12345, 0, 0);
        wait_idle();

        write_settings(2, 1);
        push_ramps(180);
        wait_idle();

        write_settings(64, 65535);
        push_ramps(140);
        wait_idle();

        write_settings(0, 0);            // steps saturate low, pulses vanish
        push_ramps(140);
        wait_idle();

        write_settings(127, $urandom_range(1, 200));
        push_ramps(150);
        wait_idle();

        write_settings($urandom_range(3, 63), $urandom_range(1, 100));
        push_ramps(200);
        wait_idle();

        write_settings(1, 3);
        push_ramps(150);
        wait_idle();

        if (!failed)
            $display("** phase_cycle_launch_control: PASSED **");
        else
            $display("** phase_cycle_launch_control: FAILED **");
        $finish;
    end

endmodule
